@@ hw/rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;
    localparam int CAPACITY  = 1024;
    localparam int TAG_WIDTH = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int LINK_W    = IDX_W + 1;
    localparam int OCC_W     = IDX_W + 1;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

    localparam logic [0:0] OP_INSERT = 1'b0;
    localparam logic [0:0] OP_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [0:0]           opcode;
        logic signed [31:0]   entry_key;
        logic [TAG_WIDTH-1:0] entry_tag;
    } t_in;

    typedef struct packed {
        logic signed [31:0]   popped_key;
        logic [TAG_WIDTH-1:0] popped_tag;
        logic [1:0]           status;
        logic [OCC_W-1:0]     occupancy_out;
    } t_out;

    // One pool node: entry, child links and subtree counts.
    typedef struct packed {
        logic signed [31:0]   key;
        logic [TAG_WIDTH-1:0] tag;
        logic [LINK_W-1:0]    left;
        logic [LINK_W-1:0]    right;
        logic [IDX_W-1:0]     lcnt;
        logic [IDX_W-1:0]     rcnt;
    } t_node;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE_RD,
        S_INS_RD,
        S_INS_WAIT,
        S_INS_STEP,
        S_INS_NEW,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_KIDS,
        S_POP_KWAIT,
        S_POP_STEP,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
`default_nettype none
// Simple dual-port memory: one write and one registered read per cycle.
module spq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8
) (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_we,
    input  wire  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]         i_wdata,
    input  wire  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic       [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/score_priority_queue_unit.sv @@
`default_nettype none
// Max-priority queue of (score, tag) entries kept as a count-balanced binary
// tree in a node memory of spq_pkg::CAPACITY entries. One operation is handled
// at a time, and o_ready is high only while the sequencer is idle. An insert
// reads a free node, then may swap and steers at each tree level that it walks
// and writes a fresh leaf at the bottom. A pop pulls the better child up at
// each level until a leaf child is unlinked, or releases a root that has no
// children. An insert into a full queue and a pop on an empty one go straight
// to the result. Each result also waits while an earlier result beat is still
// held in the output register. A free-node stack memory supplies and takes
// back nodes, and the occupancy selects its top. Stack entries at or past a
// fill mark read as their own index, so no clearing pass is needed after
// reset. Results leave through an output register, one beat per input beat.
module score_priority_queue_unit (
    input  wire  logic          i_clk,
    input  wire  logic          i_rst_n,
    input  wire  logic          i_valid,
    output logic                o_ready,
    input  wire  spq_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire  logic          i_ready,
    output spq_pkg::t_out       o_data
);
    localparam int IW = spq_pkg::IDX_W;
    localparam int LW = spq_pkg::LINK_W;
    localparam int OW = spq_pkg::OCC_W;
    localparam int NW = $bits(spq_pkg::t_node);

    spq_pkg::t_state r_state, n_state;

    logic [LW-1:0]                 r_root;
    logic [OW-1:0]                 r_occ;
    logic [IW:0]                   r_fill;
    logic signed [31:0]            r_key;
    logic [spq_pkg::TAG_WIDTH-1:0] r_tag;
    logic [LW-1:0]                 r_cur;
    logic                          r_par_valid;
    spq_pkg::t_node                r_node;
    spq_pkg::t_node                r_lnode;
    logic [IW-1:0]                 r_free;
    logic                          r_fresh;
    logic [IW-1:0]                 r_fraddr;
    logic signed [31:0]            r_pkey;
    logic [spq_pkg::TAG_WIDTH-1:0] r_ptag;
    logic [1:0]                    r_status;
    spq_pkg::t_out                 r_out;
    logic                          r_ovalid;

    // Node memory port.
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [NW-1:0] w_wdata;
    logic [IW-1:0] w_raddr;
    logic [NW-1:0] w_rdata;
    spq_pkg::t_node w_rnode;
    assign w_rnode = spq_pkg::t_node'(w_rdata);

    spq_ram #(.DEPTH(spq_pkg::CAPACITY), .WIDTH(NW)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Free stack; entries at or past the fill mark read as their own index.
    logic          w_fwe;
    logic [IW-1:0] w_fwaddr;
    logic [IW-1:0] w_fwdata;
    logic [IW-1:0] w_fraddr;
    logic [IW-1:0] w_frdata;

    spq_ram #(.DEPTH(spq_pkg::CAPACITY), .WIDTH(IW)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (w_fwe),
        .i_waddr(w_fwaddr),
        .i_wdata(w_fwdata),
        .i_raddr(w_fraddr),
        .o_rdata(w_frdata)
    );

    logic [IW-1:0] w_occ_idx;
    assign w_occ_idx = r_occ[IW-1:0];
    assign w_fraddr  = w_occ_idx;

    // Working values of one step.
    spq_pkg::t_node                w_upd;
    spq_pkg::t_node                w_leaf;
    logic signed [31:0]            w_ckey;
    logic [spq_pkg::TAG_WIDTH-1:0] w_ctag;
    logic                          w_go_right;
    logic [LW-1:0]                 w_ins_next;
    logic                          w_take_left;
    logic                          w_hl, w_hr;
    spq_pkg::t_node                w_cnode;
    logic [LW-1:0]                 w_clink;
    logic                          w_cleaf;
    logic                          w_full;
    logic                          w_empty;

    assign w_full     = (r_occ >= OW'(spq_pkg::CAPACITY));
    assign w_empty    = (r_occ == '0) || (r_root == spq_pkg::NIL_LINK);
    assign w_go_right = (r_node.lcnt > r_node.rcnt);
    assign w_ins_next = w_go_right ? r_node.right : r_node.left;
    assign w_hl = (r_node.left  != spq_pkg::NIL_LINK);
    assign w_hr = (r_node.right != spq_pkg::NIL_LINK);
    assign w_take_left = w_hl && (!w_hr || (r_lnode.key >= w_rnode.key));
    assign w_cnode = w_take_left ? r_lnode : w_rnode;
    assign w_clink = w_take_left ? r_node.left : r_node.right;
    assign w_cleaf = (w_cnode.left == spq_pkg::NIL_LINK) &&
                     (w_cnode.right == spq_pkg::NIL_LINK);

    // Image of a fresh leaf holding the carried entry.
    always_comb begin
        w_leaf       = '0;
        w_leaf.key   = r_key;
        w_leaf.tag   = r_tag;
        w_leaf.left  = spq_pkg::NIL_LINK;
        w_leaf.right = spq_pkg::NIL_LINK;
    end

    // Sequencer and datapath control.
    always_comb begin
        n_state  = r_state;
        w_we     = 1'b0;
        w_waddr  = r_cur[IW-1:0];
        w_wdata  = NW'(r_node);
        w_raddr  = r_cur[IW-1:0];
        w_fwe    = 1'b0;
        w_fwaddr = IW'(r_occ - 1'b1);
        w_fwdata = r_cur[IW-1:0];
        w_upd    = r_node;
        w_ckey   = r_key;
        w_ctag   = r_tag;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    if (i_data.opcode == spq_pkg::OP_INSERT) begin
                        n_state = w_full ? spq_pkg::S_DONE : spq_pkg::S_FREE_RD;
                    end else begin
                        n_state = w_empty ? spq_pkg::S_DONE : spq_pkg::S_POP_RD;
                    end
                end
            end
            spq_pkg::S_FREE_RD: begin
                n_state = (r_cur == spq_pkg::NIL_LINK)
                          ? spq_pkg::S_INS_NEW : spq_pkg::S_INS_RD;
            end
            spq_pkg::S_INS_RD:   n_state = spq_pkg::S_INS_WAIT;
            spq_pkg::S_INS_WAIT: n_state = spq_pkg::S_INS_STEP;
            spq_pkg::S_INS_STEP: begin
                // Swap when strictly better, then steer and count. An empty
                // link on the chosen side is pointed at the fresh node now.
                if (r_node.key < r_key) begin
                    w_upd.key = r_key;
                    w_upd.tag = r_tag;
                    w_ckey    = r_node.key;
                    w_ctag    = r_node.tag;
                end
                if (w_go_right) begin
                    w_upd.rcnt = r_node.rcnt + 1'b1;
                    if (r_node.right == spq_pkg::NIL_LINK) w_upd.right = {1'b0, r_free};
                end else begin
                    w_upd.lcnt = r_node.lcnt + 1'b1;
                    if (r_node.left == spq_pkg::NIL_LINK) w_upd.left = {1'b0, r_free};
                end
                w_we    = 1'b1;
                w_wdata = NW'(w_upd);
                n_state = (w_ins_next == spq_pkg::NIL_LINK)
                          ? spq_pkg::S_INS_NEW : spq_pkg::S_INS_RD;
            end
            spq_pkg::S_INS_NEW: begin
                // Fresh leaf; its parent link is already in place.
                w_waddr = r_free;
                w_wdata = NW'(w_leaf);
                w_we    = 1'b1;
                n_state = spq_pkg::S_DONE;
            end
            spq_pkg::S_POP_RD:   n_state = spq_pkg::S_POP_WAIT;
            spq_pkg::S_POP_WAIT: n_state = spq_pkg::S_POP_KIDS;
            spq_pkg::S_POP_KIDS: begin
                // A root without children is simply released.
                if (!w_hl && !w_hr) begin
                    w_fwe   = 1'b1;
                    n_state = spq_pkg::S_DONE;
                end else begin
                    w_raddr = r_node.left[IW-1:0];
                    n_state = spq_pkg::S_POP_KWAIT;
                end
            end
            spq_pkg::S_POP_KWAIT: begin
                w_raddr = r_node.right[IW-1:0];
                n_state = spq_pkg::S_POP_STEP;
            end
            spq_pkg::S_POP_STEP: begin
                // Pull up the better child; a leaf child is unlinked and freed.
                w_upd.key = w_cnode.key;
                w_upd.tag = w_cnode.tag;
                if (w_take_left) begin
                    if (r_node.lcnt != '0) w_upd.lcnt = r_node.lcnt - 1'b1;
                    if (w_cleaf) w_upd.left = spq_pkg::NIL_LINK;
                end else begin
                    if (r_node.rcnt != '0) w_upd.rcnt = r_node.rcnt - 1'b1;
                    if (w_cleaf) w_upd.right = spq_pkg::NIL_LINK;
                end
                w_we    = 1'b1;
                w_wdata = NW'(w_upd);
                if (w_cleaf) begin
                    w_fwe    = 1'b1;
                    w_fwdata = w_clink[IW-1:0];
                    n_state  = spq_pkg::S_DONE;
                end else begin
                    n_state  = spq_pkg::S_POP_KIDS;
                end
            end
            spq_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) n_state = spq_pkg::S_IDLE;
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    // Sequencer state, tree registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_root      <= spq_pkg::NIL_LINK;
            r_occ       <= '0;
            r_fill      <= '0;
            r_ovalid    <= 1'b0;
            r_fresh     <= 1'b0;
            r_par_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                spq_pkg::S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_key       <= i_data.entry_key;
                        r_tag       <= i_data.entry_tag;
                        r_cur       <= r_root;
                        r_par_valid <= 1'b0;
                        r_fraddr    <= w_occ_idx;
                        r_fresh     <= ({1'b0, w_occ_idx} >= r_fill);
                        r_pkey      <= '0;
                        r_ptag      <= '0;
                        if (i_data.opcode == spq_pkg::OP_INSERT) begin
                            r_status <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                        end else begin
                            r_status <= w_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
                        end
                    end
                end
                spq_pkg::S_FREE_RD: begin
                    r_free <= r_fresh ? r_fraddr : w_frdata;
                end
                spq_pkg::S_INS_WAIT: r_node <= w_rnode;
                spq_pkg::S_INS_STEP: begin
                    r_key       <= w_ckey;
                    r_tag       <= w_ctag;
                    r_par_valid <= 1'b1;
                    r_cur       <= w_ins_next;
                end
                spq_pkg::S_INS_NEW: begin
                    r_occ <= r_occ + 1'b1;
                    if (r_fresh) r_fill <= {1'b0, r_fraddr} + 1'b1;
                    if (!r_par_valid) r_root <= {1'b0, r_free};
                end
                spq_pkg::S_POP_WAIT: begin
                    r_node <= w_rnode;
                    r_pkey <= w_rnode.key;
                    r_ptag <= w_rnode.tag;
                end
                spq_pkg::S_POP_KIDS: begin
                    if (!w_hl && !w_hr) begin
                        r_occ  <= r_occ - 1'b1;
                        r_root <= spq_pkg::NIL_LINK;
                    end
                end
                spq_pkg::S_POP_KWAIT: r_lnode <= w_rnode;
                spq_pkg::S_POP_STEP: begin
                    r_node <= w_cnode;
                    r_cur  <= w_clink;
                    if (w_cleaf) r_occ <= r_occ - 1'b1;
                end
                default: ;
            endcase
            if (r_state == spq_pkg::S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid            <= 1'b1;
                r_out.popped_key    <= r_pkey;
                r_out.popped_tag    <= r_ptag;
                r_out.status        <= r_status;
                r_out.occupancy_out <= r_occ;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == spq_pkg::S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    ap_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(spq_pkg::CAPACITY))
        else $error("occupancy beyond capacity");
    ap_root_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::S_IDLE) |-> ((r_occ == '0) == (r_root == spq_pkg::NIL_LINK)))
        else $error("root link disagrees with occupancy");
    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !(r_state == spq_pkg::S_DONE))
        else $error("ready while finishing");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result beat changed while stalled");
`endif
endmodule
`default_nettype wire

@@ sim/score_priority_queue_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the queue, predicts every result beat and compares.
module score_priority_queue_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_o_ready,
    input  wire spq_pkg::t_in  i_data,
    input  wire logic          i_o_valid,
    input  wire logic          i_ready,
    input  wire spq_pkg::t_out i_o_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int CAP = spq_pkg::CAPACITY;
    localparam int TW  = spq_pkg::TAG_WIDTH;
    localparam int OW  = spq_pkg::OCC_W;

    // Shadow copy of the tree and the free-node stack.
    logic signed [31:0] tree_key[CAP];
    logic [TW-1:0]      tree_tag[CAP];
    int                 tree_left[CAP];
    int                 tree_right[CAP];
    int                 left_cnt[CAP];
    int                 right_cnt[CAP];
    int                 free_stack[CAP];
    int                 root_node;
    int                 held;
    spq_pkg::t_out      pending_results[$];

    function automatic void clear_tree();
        for (int i = 0; i < CAP; i++) begin
            tree_key[i] = '0;
            tree_tag[i] = '0;
            tree_left[i] = CAP;
            tree_right[i] = CAP;
            left_cnt[i] = 0;
            right_cnt[i] = 0;
            free_stack[i] = i;
        end
        root_node = CAP;
        held = 0;
    endfunction

    // A slot is the link held by a parent on one side; no parent means the root.
    function automatic int link_at(int parent, bit go_right);
        if (parent < 0) return root_node;
        return go_right ? tree_right[parent] : tree_left[parent];
    endfunction

    function automatic void link_write(int parent, bit go_right, int value);
        if (parent < 0) root_node = value;
        else if (go_right) tree_right[parent] = value;
        else tree_left[parent] = value;
    endfunction

    function automatic void insert_entry(logic signed [31:0] key, logic [TW-1:0] tag);
        int parent;
        bit go_right;
        int guard;
        int n;
        int f;
        logic signed [31:0] tmp_key;
        logic [TW-1:0] tmp_tag;
        parent = -1;
        go_right = 0;
        guard = 0;
        while (link_at(parent, go_right) < CAP && guard <= CAP) begin
            n = link_at(parent, go_right);
            // A strictly better carried entry takes this node's place.
            if (tree_key[n] < key) begin
                tmp_key = tree_key[n];
                tmp_tag = tree_tag[n];
                tree_key[n] = key;
                tree_tag[n] = tag;
                key = tmp_key;
                tag = tmp_tag;
            end
            if (left_cnt[n] > right_cnt[n]) begin
                right_cnt[n]++;
                go_right = 1;
            end else begin
                left_cnt[n]++;
                go_right = 0;
            end
            parent = n;
            guard++;
        end
        f = free_stack[held % CAP] % CAP;
        held++;
        tree_key[f] = key;
        tree_tag[f] = tag;
        tree_left[f] = CAP;
        tree_right[f] = CAP;
        left_cnt[f] = 0;
        right_cnt[f] = 0;
        link_write(parent, go_right, f);
    endfunction

    function automatic void pop_entry();
        int parent;
        bit go_right;
        int guard;
        int n;
        int l;
        int r;
        parent = -1;
        go_right = 0;
        guard = 0;
        while (link_at(parent, go_right) < CAP && guard <= CAP) begin
            n = link_at(parent, go_right);
            l = tree_left[n];
            r = tree_right[n];
            // A leaf is unlinked and returned to the free stack.
            if (l >= CAP && r >= CAP) begin
                link_write(parent, go_right, CAP);
                if (held > 0) begin
                    held--;
                    free_stack[held % CAP] = n;
                end
                return;
            end
            // Pull up the better child; ties go left.
            if (l < CAP && (r >= CAP || tree_key[l] >= tree_key[r])) begin
                tree_key[n] = tree_key[l];
                tree_tag[n] = tree_tag[l];
                if (left_cnt[n] > 0) left_cnt[n]--;
                go_right = 0;
            end else begin
                tree_key[n] = tree_key[r];
                tree_tag[n] = tree_tag[r];
                if (right_cnt[n] > 0) right_cnt[n]--;
                go_right = 1;
            end
            parent = n;
            guard++;
        end
    endfunction

    function automatic spq_pkg::t_out queue_step(spq_pkg::t_in item);
        spq_pkg::t_out res;
        res = '0;
        if (item.opcode == spq_pkg::OP_INSERT) begin
            if (held >= CAP) res.status = spq_pkg::ST_FULL;
            else insert_entry(item.entry_key, item.entry_tag);
        end else begin
            if (held == 0 || root_node >= CAP) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.popped_key = tree_key[root_node];
                res.popped_tag = tree_tag[root_node];
                pop_entry();
            end
        end
        res.occupancy_out = OW'(held);
        return res;
    endfunction

    // Result beats are matched first; an input accepted now cannot answer at once.
    always @(posedge i_clk) begin
        spq_pkg::t_out want;
        if (!i_rst_n) begin
            clear_tree();
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %h", i_o_data);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.popped_key !== i_o_data.popped_key ||
                        want.popped_tag !== i_o_data.popped_tag ||
                        want.status !== i_o_data.status ||
                        want.occupancy_out !== i_o_data.occupancy_out) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: want key %0d tag %h st %0d occ %0d,",
                                      " got key %0d tag %h st %0d occ %0d"},
                                     want.popped_key, want.popped_tag, want.status,
                                     want.occupancy_out, i_o_data.popped_key,
                                     i_o_data.popped_tag, i_o_data.status,
                                     i_o_data.occupancy_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && i_o_ready)
                pending_results.push_back(queue_step(i_data));
        end
        o_pending = pending_results.size();
    end
endmodule

@@ sim/score_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps
module score_priority_queue_unit_tb;
    localparam int STALL_LIMIT = 4000;
    localparam int TW          = spq_pkg::TAG_WIDTH;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    spq_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    spq_pkg::t_out o_data;
    int            fail_count;
    int            pending;
    int            idle_pct;
    int            idle_cycles;
    bit            calm;

    score_priority_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    score_priority_queue_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_ready(o_ready),
        .i_data(i_data), .i_o_valid(o_valid), .i_ready(i_ready), .i_o_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // The receiver stalls at random unless a calm stretch is running.
    always @(negedge i_clk)
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= idle_pct);

    // Watchdog on cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drives one input beat from a falling edge and returns at a falling edge.
    task automatic send_beat(logic [0:0] op, logic signed [31:0] key,
                             logic [TW-1:0] tag);
        if (!calm) begin
            while ($urandom_range(99) < idle_pct) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data <= '{opcode: op, entry_key: key, entry_tag: tag};
        while (!o_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_burst(int count, int insert_pct, bit narrow_keys);
        logic signed [31:0] key;
        for (int i = 0; i < count; i++) begin
            key = narrow_keys ? 32'($signed($urandom_range(0, 6)) - 3) : $urandom;
            if ($urandom_range(99) < insert_pct)
                send_beat(spq_pkg::OP_INSERT, key, TW'($urandom_range(0, 65535)));
            else
                send_beat(spq_pkg::OP_POP, key, TW'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        idle_pct = 18;
        calm = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: pop on empty, extreme scores and tags, and equal scores.
        send_beat(spq_pkg::OP_POP, '0, '0);
        send_beat(spq_pkg::OP_INSERT, 32'sh7FFFFFFF, 16'hFFFF);
        send_beat(spq_pkg::OP_INSERT, 32'sh80000000, 16'h0000);
        send_beat(spq_pkg::OP_INSERT, 32'sd0, 16'h0001);
        send_beat(spq_pkg::OP_INSERT, 32'sd0, 16'h0002);
        send_beat(spq_pkg::OP_INSERT, 32'sd0, 16'h0003);
        send_beat(spq_pkg::OP_INSERT, -32'sd1, 16'h8000);
        send_beat(spq_pkg::OP_INSERT, 32'sh7FFFFFFF, 16'h5555);
        send_beat(spq_pkg::OP_INSERT, 32'sh80000000, 16'hAAAA);
        for (int i = 0; i < 9; i++) send_beat(spq_pkg::OP_POP, 32'sh7FFFFFFF, 16'hFFFF);
        send_beat(spq_pkg::OP_POP, '0, '0);

        // Mixed traffic with a calm stretch and a pause until every pending result is delivered.
        random_burst(140, 65, 0);
        calm = 1;
        random_burst(110, 55, 1);
        calm = 0;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        random_burst(140, 50, 1);
        random_burst(120, 35, 0);

        // Drain the queue past empty.
        for (int i = 0; i < 80; i++)
            send_beat(spq_pkg::OP_POP, '0, '0);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
